[src/slot_timer_with_period_offset_top_defines.svh]
// ----------------------------------------------------------------------------
// Slot timer assertion macros
// Shared assertion helpers for the slot timer RTL, clocked on clk and
// disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef SLOT_TIMER_WITH_PERIOD_OFFSET_TOP_DEFINES_SVH
`define SLOT_TIMER_WITH_PERIOD_OFFSET_TOP_DEFINES_SVH

// Check a property on every rising edge outside reset
`define STM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition is followed by an expression in the next cycle
`define STM_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);

`endif

[src/stm_pkg.sv]
// ----------------------------------------------------------------------------
// Slot timer package
// Types, command codes, register indexes and reset constants shared by the
// slot timer modules.
// ----------------------------------------------------------------------------
package stm_pkg;

  // Counter width default and widest supported counter
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int COUNT_MAX_W     = 32;

  // Configuration register widths and reset values
  localparam int TPU_W   = 5;
  localparam int GUARD_W = 10;
  localparam int PADDR_W = 3;
  localparam logic [TPU_W-1:0]       TPU_RESET         = 5'd16;
  localparam logic [GUARD_W-1:0]     GUARD_RESET       = 10'd50;
  localparam logic [COUNT_MAX_W-1:0] SLOT_PERIOD_RESET = 32'd1600000;

  // Input field widths
  localparam int PERIOD_US_W = 24;
  localparam int OFFSET_US_W = 21;

  // Register indexes, taken from paddr[2]
  localparam logic REG_TICKS_PER_US = 1'b0;
  localparam logic REG_GUARD_TICKS  = 1'b1;

  // Command codes
  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_START  = 3'd1,
    CMD_SET    = 3'd2,
    CMD_OFFSET = 3'd3,
    CMD_READ   = 3'd4
  } cmd_t;

  // Item after the input stage, with microseconds already scaled to ticks
  typedef struct packed {
    cmd_t                   cmd;
    logic [COUNT_MAX_W-1:0] period_ticks;
    logic [COUNT_MAX_W-1:0] delta_ticks;
  } item_t;

  // Result held in the output register
  typedef struct packed {
    logic [31:0] slot_elapsed;
    logic        offset_applied;
    logic        slot_event;
  } result_t;

endpackage

[src/stm_apb_regs.sv]
// ----------------------------------------------------------------------------
// Slot timer configuration registers
// APB-style write and read access to ticks_per_us and guard_ticks.
// ----------------------------------------------------------------------------
module stm_apb_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [stm_pkg::PADDR_W-1:0]       paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  output logic [stm_pkg::TPU_W-1:0]         ticks_per_us,
  output logic [stm_pkg::GUARD_W-1:0]       guard_ticks
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Write a register on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_us <= stm_pkg::TPU_RESET;
      guard_ticks  <= stm_pkg::GUARD_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        stm_pkg::REG_TICKS_PER_US: ticks_per_us <= pwdata[stm_pkg::TPU_W-1:0];
        stm_pkg::REG_GUARD_TICKS:  guard_ticks  <= pwdata[stm_pkg::GUARD_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (paddr[2])
      stm_pkg::REG_TICKS_PER_US: prdata = 32'(ticks_per_us);
      stm_pkg::REG_GUARD_TICKS:  prdata = 32'(guard_ticks);
      default:                   prdata = '0;
    endcase
  end

endmodule

[src/stm_in_stage.sv]
// ----------------------------------------------------------------------------
// Slot timer input stage
// Registers each input transfer and scales its microsecond fields to ticks.
// ----------------------------------------------------------------------------
module stm_in_stage (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [2:0]                        cmd,
  input  logic [stm_pkg::PERIOD_US_W-1:0]   period_us,
  input  logic signed [stm_pkg::OFFSET_US_W-1:0] offset_us,
  input  logic [stm_pkg::TPU_W-1:0]         ticks_per_us,
  input  logic                              core_take,
  output logic                              item_valid,
  output stm_pkg::item_t                    item
);

  logic [31:0]    tpu_ext;
  logic [31:0]    period_ext;
  logic [31:0]    offset_ext;
  stm_pkg::item_t item_next;

  // Scale both fields; products wrap at 32 bits
  assign tpu_ext    = 32'(ticks_per_us);
  assign period_ext = 32'(period_us);
  assign offset_ext = 32'(offset_us);

  always_comb begin
    item_next.cmd          = stm_pkg::cmd_t'(cmd);
    item_next.period_ticks = period_ext * tpu_ext;
    item_next.delta_ticks  = offset_ext * tpu_ext;
  end

  // Take a new transfer when empty or when the core takes the held one
  assign s_tready = !item_valid || core_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  // Hold the payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item <= item_next;
    end
  end

endmodule

[src/stm_core.sv]
// ----------------------------------------------------------------------------
// Slot timer core
// Holds the counter, compare, period and stash, executes one item per cycle
// while its output register is free or being emptied, and registers its result.
// ----------------------------------------------------------------------------
`include "slot_timer_with_period_offset_top_defines.svh"

module stm_core #(
  parameter int COUNT_WIDTH = stm_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  input  stm_pkg::item_t                    item,
  input  logic [stm_pkg::GUARD_W-1:0]       guard_ticks,
  output logic                              core_take,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output stm_pkg::result_t                  res
);

  localparam int CW = COUNT_WIDTH;

  logic [CW-1:0] tick_count,     tick_count_next;
  logic [CW-1:0] compare_value,  compare_value_next;
  logic [CW-1:0] slot_period,    slot_period_next;
  logic [CW-1:0] stashed_period, stashed_period_next;
  logic          stash_valid,    stash_valid_next;
  logic          armed,          armed_next;
  stm_pkg::result_t res_next;

  logic          exec;
  logic [CW-1:0] count_inc;
  logic [CW-1:0] period_use;
  logic [CW-1:0] target;
  logic [CW-1:0] limit;
  logic [CW-1:0] left;

  // Execute when the output register is free or being emptied
  assign core_take = !m_tvalid || m_tready;
  assign exec      = item_valid && core_take;

  assign count_inc  = tick_count + 1'b1;
  assign period_use = stash_valid ? stashed_period : slot_period;
  assign target     = compare_value + item.delta_ticks[CW-1:0];
  assign limit      = tick_count + CW'(guard_ticks);
  assign left       = compare_value - tick_count;

  // Decode the command and work out the next state and result
  always_comb begin
    tick_count_next     = tick_count;
    compare_value_next  = compare_value;
    slot_period_next    = slot_period;
    stashed_period_next = stashed_period;
    stash_valid_next    = stash_valid;
    armed_next          = armed;
    res_next            = '0;
    unique case (item.cmd)
      stm_pkg::CMD_TICK: begin
        tick_count_next = count_inc;
        if (armed && count_inc == compare_value) begin
          res_next.slot_event = 1'b1;
          slot_period_next    = period_use;
          stash_valid_next    = 1'b0;
          compare_value_next  = compare_value + period_use;
        end
      end
      stm_pkg::CMD_START: begin
        compare_value_next = tick_count + slot_period;
        armed_next         = 1'b1;
      end
      stm_pkg::CMD_SET: begin
        slot_period_next   = item.period_ticks[CW-1:0];
        compare_value_next = tick_count + item.period_ticks[CW-1:0];
      end
      stm_pkg::CMD_OFFSET: begin
        if (target > limit) begin
          stashed_period_next     = slot_period;
          stash_valid_next        = 1'b1;
          slot_period_next        = slot_period + item.delta_ticks[CW-1:0];
          compare_value_next      = target;
          res_next.offset_applied = 1'b1;
        end
      end
      stm_pkg::CMD_READ: begin
        res_next.slot_elapsed = 32'(slot_period - left);
      end
      default: ;
    endcase
  end

  // Update the timer state
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count     <= '0;
      compare_value  <= '0;
      slot_period    <= stm_pkg::SLOT_PERIOD_RESET[CW-1:0];
      stashed_period <= '0;
      stash_valid    <= 1'b0;
      armed          <= 1'b0;
    end else if (exec) begin
      tick_count     <= tick_count_next;
      compare_value  <= compare_value_next;
      slot_period    <= slot_period_next;
      stashed_period <= stashed_period_next;
      stash_valid    <= stash_valid_next;
      armed          <= armed_next;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (core_take) begin
      m_tvalid <= item_valid;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (exec) begin
      res <= res_next;
    end
  end

  // Once armed, the timer stays armed until reset
  `STM_ASSERT_NEXT(a_armed_holds, armed, armed, "armed flag dropped")
  // Only a tick can raise a slot event
  `STM_ASSERT_NEXT(a_event_on_tick, exec && item.cmd != stm_pkg::CMD_TICK, !res.slot_event, "slot event outside tick")
  // A tick advances the counter by one
  `STM_ASSERT_NEXT(a_tick_counts, exec && item.cmd == stm_pkg::CMD_TICK, tick_count == CW'($past(tick_count) + 1'b1), "tick did not advance counter")
  // A new stash is always reported as an applied offset
  `STM_ASSERT(a_stash_reported, $rose(stash_valid) |-> res.offset_applied && m_tvalid, "stash without applied offset")

endmodule

[src/slot_timer_with_period_offset_top.sv]
// Path: each input transfer is held in the input register, its result then in the output register.
// Throughput: one item per cycle unless m_tready stalls the result stream; the state update loop in stm_core sets this.
// While a result waits on m_tready the input register takes one more item, then s_tready drops.
// Reset: synchronous rst clears both pipeline valids, zeroes counter, compare and stash,
// disarms the timer, loads the 1600000-tick period and the register reset values.
// ----------------------------------------------------------------------------
// Slot timer with period offset, top level
// Periodic compare timer with stashed period and guarded one-slot offset,
// streaming command input, streaming result output and APB-style registers.
// ----------------------------------------------------------------------------
module slot_timer_with_period_offset_top #(
  parameter int COUNT_WIDTH = stm_pkg::COUNT_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // Command stream
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [47:0]                 s_tdata,  // period_us[23:0], offset_us[44:24], zero pad
  input  logic [2:0]                  s_tuser,  // cmd[2:0]
  // Result stream
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [39:0]                 m_tdata,  // slot_event[0], offset_applied[1],
                                                // slot_elapsed[33:2], zero pad
  // Configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [stm_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic [stm_pkg::TPU_W-1:0]   ticks_per_us;
  logic [stm_pkg::GUARD_W-1:0] guard_ticks;
  logic                        core_take;
  logic                        item_valid;
  stm_pkg::item_t              item;
  stm_pkg::result_t            res;

  stm_apb_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .ticks_per_us (ticks_per_us),
    .guard_ticks  (guard_ticks)
  );

  stm_in_stage u_in (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .cmd          (s_tuser),
    .period_us    (s_tdata[23:0]),
    .offset_us    (s_tdata[44:24]),
    .ticks_per_us (ticks_per_us),
    .core_take    (core_take),
    .item_valid   (item_valid),
    .item         (item)
  );

  stm_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item        (item),
    .guard_ticks (guard_ticks),
    .core_take   (core_take),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .res         (res)
  );

  // Pack the result transfer
  assign m_tdata = {6'b0, res.slot_elapsed, res.offset_applied, res.slot_event};

endmodule

[verif/slot_timer_with_period_offset_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Slot timer with period offset, testbench
// Drives timer commands over the command stream and register writes over the
// APB port. It predicts every result with a cycle-free model of the counter,
// the compare, the period and the stash, then checks each result transfer in
// order. A short directed part is followed by random phases under several
// tick-rate and guard settings.
// ----------------------------------------------------------------------------
module slot_timer_with_period_offset_top_tb;

  typedef struct {
    logic [2:0]  op;
    logic [23:0] period_us;
    logic [20:0] offset_us;
  } timer_cmd_t;

  localparam int MAX_SHOWN      = 10;
  localparam int IDLE_PCT       = 23;
  localparam int CALM_FROM      = 400;
  localparam int CALM_TO        = 900;
  localparam int RAND_PER_PHASE = 115;
  localparam int NUM_PHASES     = 6;
  localparam int TIMEOUT_NS     = 200000;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata  = '0;   // period_us[23:0], offset_us[44:24], zero pad
  logic [2:0]  s_tuser  = '0;   // cmd[2:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;         // slot_event[0], offset_applied[1], slot_elapsed[33:2]
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [stm_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  slot_timer_with_period_offset_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #1 clk = ~clk;

  // Predicted timer state and register copies
  logic [stm_pkg::TPU_W-1:0]   tpu_copy;
  logic [stm_pkg::GUARD_W-1:0] guard_copy;
  logic [31:0]        tick_cnt;
  logic [31:0]        cmp_val;
  logic [31:0]        period;
  logic [31:0]        stash;
  logic               stash_held;
  logic               armed;

  timer_cmd_t       timer_cmds_q[$];
  stm_pkg::result_t slot_results_q[$];
  int         mismatch_cnt = 0;
  int         cycle_n      = 0;
  bit         cmd_taken    = 1'b0;

  task automatic reset_timer_model();
    tpu_copy   = stm_pkg::TPU_RESET;
    guard_copy = stm_pkg::GUARD_RESET;
    tick_cnt   = '0;
    cmp_val    = '0;
    period     = stm_pkg::SLOT_PERIOD_RESET;
    stash      = '0;
    stash_held = 1'b0;
    armed      = 1'b0;
  endtask

  // Advance the predicted timer by one command and return its result
  function automatic stm_pkg::result_t timer_step(timer_cmd_t c);
    stm_pkg::result_t r;
    logic [31:0] delta;
    logic [31:0] target;
    logic [31:0] limit;
    r = '0;
    case (c.op)
      stm_pkg::CMD_TICK: begin
        tick_cnt = tick_cnt + 32'd1;
        if (armed && tick_cnt == cmp_val) begin
          r.slot_event = 1'b1;
          if (stash_held) begin
            period     = stash;
            stash_held = 1'b0;
          end
          cmp_val = cmp_val + period;
        end
      end
      stm_pkg::CMD_START: begin
        cmp_val = tick_cnt + period;
        armed   = 1'b1;
      end
      stm_pkg::CMD_SET: begin
        period  = 32'(c.period_us) * 32'(tpu_copy);
        cmp_val = tick_cnt + period;
      end
      stm_pkg::CMD_OFFSET: begin
        delta  = {{11{c.offset_us[20]}}, c.offset_us} * 32'(tpu_copy);
        target = cmp_val + delta;
        limit  = tick_cnt + 32'(guard_copy);
        if (target > limit) begin
          stash            = period;
          stash_held       = 1'b1;
          period           = period + delta;
          cmp_val          = target;
          r.offset_applied = 1'b1;
        end
      end
      stm_pkg::CMD_READ: r.slot_elapsed = period - (cmp_val - tick_cnt);
      default: ;
    endcase
    return r;
  endfunction

  function automatic bit idle_now();
    if (cycle_n >= CALM_FROM && cycle_n < CALM_TO) return 1'b0;
    return $urandom_range(0, 99) < IDLE_PCT;
  endfunction

  function automatic timer_cmd_t mk_cmd(logic [2:0] op, logic [23:0] p_us, logic [20:0] o_us);
    timer_cmd_t c;
    c.op        = op;
    c.period_us = p_us;
    c.offset_us = o_us;
    return c;
  endfunction

  // Random command; fields the command ignores carry random bits
  function automatic timer_cmd_t rand_cmd();
    timer_cmd_t  c;
    int unsigned pick;
    int unsigned span;
    c.period_us = 24'($urandom);
    c.offset_us = 21'($urandom);
    span = (tpu_copy == 0) ? 40 : 48 / tpu_copy + 1;
    pick = $urandom_range(0, 99);
    if (pick < 58) begin
      c.op = stm_pkg::CMD_TICK;
    end else if (pick < 70) begin
      c.op = stm_pkg::CMD_OFFSET;
      if ($urandom_range(0, 9) != 0)
        c.offset_us = 21'(int'($urandom_range(0, 2 * span)) - int'(span));
    end else if (pick < 80) begin
      c.op = stm_pkg::CMD_READ;
    end else if (pick < 87) begin
      c.op = stm_pkg::CMD_SET;
      if ($urandom_range(0, 9) != 0) c.period_us = 24'($urandom_range(1, span));
    end else if (pick < 96) begin
      c.op = stm_pkg::CMD_START;
    end else begin
      c.op = 3'(stm_pkg::CMD_READ) + 3'($urandom_range(1, 3));
    end
    return c;
  endfunction

  // Register write: setup cycle, then access cycle until pready
  task automatic write_reg(input logic reg_idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (reg_idx == stm_pkg::REG_TICKS_PER_US) tpu_copy = value[stm_pkg::TPU_W-1:0];
    else guard_copy = value[stm_pkg::GUARD_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write both registers; unused upper bits carry noise
  task automatic set_timing(input int unsigned tpu, input int unsigned guard);
    write_reg(stm_pkg::REG_TICKS_PER_US, ($urandom & ~32'h1f) | 32'(tpu));
    write_reg(stm_pkg::REG_GUARD_TICKS, ($urandom & ~32'h3ff) | 32'(guard));
  endtask

  // Hold until every command is taken and every result has come back
  task automatic drain();
    while (timer_cmds_q.size() != 0 || slot_results_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Stream driver: present the head of the command queue, randomise m_tready
  always @(negedge clk) begin
    timer_cmd_t c;
    cycle_n++;
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !idle_now();
      if (!s_tvalid || cmd_taken) begin
        cmd_taken = 1'b0;
        if (timer_cmds_q.size() != 0 && !idle_now()) begin
          c = timer_cmds_q[0];
          s_tvalid <= 1'b1;
          s_tuser  <= c.op;
          s_tdata  <= {3'b000, c.offset_us, c.period_us};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check result transfers, then predict for command transfers
  always @(posedge clk) begin
    stm_pkg::result_t got;
    stm_pkg::result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[33:0];
        if (slot_results_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_SHOWN)
            $display("unexpected result transfer: %h", got);
        end else begin
          want = slot_results_q.pop_front();
          if (got.slot_event !== want.slot_event ||
              got.offset_applied !== want.offset_applied ||
              got.slot_elapsed !== want.slot_elapsed) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_SHOWN)
              $display("result mismatch: event %b/%b applied %b/%b elapsed %0d/%0d (exp/got)",
                       want.slot_event, got.slot_event, want.offset_applied,
                       got.offset_applied, want.slot_elapsed, got.slot_elapsed);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        slot_results_q.push_back(timer_step(timer_cmds_q.pop_front()));
        cmd_taken = 1'b1;
      end
    end
  end

  // Stimulus
  initial begin
    int unsigned tpu_set[NUM_PHASES]   = '{1, 2, 0, 31, 4, 16};
    int unsigned guard_set[NUM_PHASES] = '{0, 5, 1023, 0, 50, 1023};
    reset_timer_model();
    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Reset settings: unarmed tick, unknown commands, field extremes
    timer_cmds_q.push_back(mk_cmd(stm_pkg::CMD_READ, '0, '0));
    timer_cmds_q.push_back(mk_cmd(stm_pkg::CMD_TICK, '1, '1));
    timer_cmds_q.push_back(mk_cmd(3'(stm_pkg::CMD_READ) + 3'd1, '1, '1));
    timer_cmds_q.push_back(mk_cmd(3'(stm_pkg::CMD_READ) + 3'd3, '1, '1));
    timer_cmds_q.push_back(mk_cmd(stm_pkg::CMD_OFFSET, '0, 21'h100000));
    timer_cmds_q.push_back(mk_cmd(stm_pkg::CMD_OFFSET, '1, 21'h0fffff));
    timer_cmds_q.push_back(mk_cmd(stm_pkg::CMD_SET, 24'hffffff, '0));
    timer_cmds_q.push_back(mk_cmd(stm_pkg::CMD_SET, '0, '1));
    drain();

    // One tick per microsecond, no guard: slot event, repeated offset, zero stash
    set_timing(1, 0);
    timer_cmds_q.push_back(mk_cmd(stm_pkg::CMD_SET, 24'd3, '0));
    timer_cmds_q.push_back(mk_cmd(stm_pkg::CMD_START, '0, '0));
    repeat (3) timer_cmds_q.push_back(mk_cmd(stm_pkg::CMD_TICK, '0, '0));
    timer_cmds_q.push_back(mk_cmd(stm_pkg::CMD_OFFSET, '0, 21'd2));
    timer_cmds_q.push_back(mk_cmd(stm_pkg::CMD_OFFSET, '0, 21'd1));
    timer_cmds_q.push_back(mk_cmd(stm_pkg::CMD_READ, '0, '0));
    repeat (6) timer_cmds_q.push_back(mk_cmd(stm_pkg::CMD_TICK, '0, '0));
    timer_cmds_q.push_back(mk_cmd(stm_pkg::CMD_READ, '0, '0));
    timer_cmds_q.push_back(mk_cmd(stm_pkg::CMD_SET, '0, '0));
    timer_cmds_q.push_back(mk_cmd(stm_pkg::CMD_START, '0, '0));
    timer_cmds_q.push_back(mk_cmd(stm_pkg::CMD_OFFSET, '0, 21'd3));
    repeat (4) timer_cmds_q.push_back(mk_cmd(stm_pkg::CMD_TICK, '0, '0));
    drain();

    // Random phases, each opened by a set period and a start
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_timing(tpu_set[p], guard_set[p]);
      timer_cmds_q.push_back(mk_cmd(stm_pkg::CMD_SET, 24'd2, '0));
      timer_cmds_q.push_back(mk_cmd(stm_pkg::CMD_START, '0, '0));
      repeat (RAND_PER_PHASE) timer_cmds_q.push_back(rand_cmd());
      drain();
    end

    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0 && slot_results_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("status: fail");
    $finish;
  end

endmodule
